// ----- src/sobel_edge_magnitude_assert.svh -----
// Assertion helpers, clocked on clk, quiet while rst_n is low.
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH

// Same-cycle implication.
`define SEM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sem assertion failed");

// Next-cycle implication.
`define SEM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sem assertion failed");

`endif

// ----- src/sem_pkg.sv -----
`timescale 1ns / 1ps
package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int HIST_DEPTH = 2 * MAX_WIDTH + 3;
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int DIM_W      = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int POS_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  // register field widths
  localparam int WREG_W    = 11;
  localparam int HREG_W    = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  // gradient arithmetic: |g| <= 4*255
  localparam int G_W        = 11;
  localparam int SQ_W       = 20;
  localparam int N_W        = 21;
  localparam int ROOT_STEPS = 11;
  localparam int CNT_W      = 4;
  localparam int KS_W       = 4;
  localparam int LAST_K     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_edge;
    logic [7:0] green_edge;
    logic [7:0] blue_edge;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [HGT_W-1:0] h;
  } dims_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [IDX_W-1:0] idx;
    logic             last;
  } job_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [23:0]      data;
  } hist_wr_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_DRAIN,
    B_SQ,
    B_SUM,
    B_ROOT,
    B_FIN
  } back_state_t;

  // window offsets: 0 = minus one, 1 = centre, 2 = plus one
  function automatic logic [1:0] win_row(input logic [KS_W-1:0] k);
    unique case (k)
      4'd0, 4'd1, 4'd2: win_row = 2'd0;
      4'd3, 4'd4, 4'd5: win_row = 2'd1;
      default:          win_row = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] win_col(input logic [KS_W-1:0] k);
    unique case (k)
      4'd0, 4'd3, 4'd6: win_col = 2'd0;
      4'd1, 4'd4, 4'd7: win_col = 2'd1;
      default:          win_col = 2'd2;
    endcase
  endfunction

  function automatic logic signed [2:0] kern_x(input logic [KS_W-1:0] k);
    unique case (k)
      4'd0, 4'd6: kern_x = -3'sd1;
      4'd2, 4'd8: kern_x = 3'sd1;
      4'd3:       kern_x = -3'sd2;
      4'd5:       kern_x = 3'sd2;
      default:    kern_x = 3'sd0;
    endcase
  endfunction

  function automatic logic signed [2:0] kern_y(input logic [KS_W-1:0] k);
    unique case (k)
      4'd0, 4'd2: kern_y = -3'sd1;
      4'd6, 4'd8: kern_y = 3'sd1;
      4'd1:       kern_y = -3'sd2;
      4'd7:       kern_y = 3'sd2;
      default:    kern_y = 3'sd0;
    endcase
  endfunction

  function automatic logic signed [G_W-1:0] weigh(input logic [7:0] v,
                                                  input logic signed [2:0] wgt);
    logic signed [G_W-1:0] vs;
    vs = signed'(G_W'(v));
    unique case (wgt)
      3'sd1:   weigh = vs;
      3'sd2:   weigh = vs <<< 1;
      -3'sd1:  weigh = -vs;
      -3'sd2:  weigh = -(vs <<< 1);
      default: weigh = '0;
    endcase
  endfunction

endpackage

// ----- src/sobel_edge_magnitude.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Beat
// in      | input     | in_valid/in_stall  | in_item: kind, red/green/blue pixel
// out     | output    | out_valid/out_stall| out_item: red/green/blue edge, frame_last
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data (width, height)
//
// A beat that yields no result is taken whenever in_stall is low.
// A beat that yields a result holds the input while the 3x3 window
// is read from the single read port of the history memory; the magnitude then
// goes through drain, square, sum, an 11-step root and output load while later
// beats go in; the next beat that yields a result waits in the job slot till then.
// Reset is synchronous on rst_n low; the history memory is not cleared.
// A stalled result waits in the output register and backs up the job slot.
module sobel_edge_magnitude (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sem_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sem_pkg::out_item_t            out_item
);
  import sem_pkg::*;

  logic     q_push, q_ready, q_pop, q_valid, rd_busy;
  job_t     push_job, pop_job;
  hist_wr_t hist_wr;
  dims_t    dims;

  // front: position counters, history writes, decides which beat emits
  sem_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_ready   (q_ready),
    .rd_busy   (rd_busy),
    .q_push    (q_push),
    .q_job     (push_job),
    .hist_wr   (hist_wr),
    .dims      (dims)
  );

  // one pending output position between the two halves
  sem_jobq u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_job    (pop_job)
  );

  // back: window gather, gradients, rounded root, output register
  sem_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_in    (pop_job),
    .job_pop   (q_pop),
    .rd_busy   (rd_busy),
    .hist_wr   (hist_wr),
    .dims      (dims),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- src/sem_front.sv -----
`timescale 1ns / 1ps
module sem_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  sem_pkg::in_item_t  in_item,
  input  logic               q_ready,
  input  logic               rd_busy,
  output logic               q_push,
  output sem_pkg::job_t      q_job,
  output sem_pkg::hist_wr_t  hist_wr,
  output sem_pkg::dims_t     dims
);
  import sem_pkg::*;

  logic [WREG_W-1:0] width_r;
  logic [HREG_W-1:0] height_r;
  logic [POS_W-1:0]  in_pos_r, out_pos_r;
  logic [IDX_W-1:0]  in_idx_r, out_idx_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;

  logic [DIM_W-1:0]  w_c;
  logic [HGT_W-1:0]  h_c;
  logic [POS_W-1:0]  total, in_pos_inc, pos_gap;
  logic              accept, is_pix, emit, last, cfg_wr;
  logic [IDX_W-1:0]  in_idx_nxt, out_idx_nxt;

  // clamp the raw register values
  always_comb begin
    if (width_r == '0) begin
      w_c = DIM_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_c = DIM_W'(MAX_WIDTH);
    end else begin
      w_c = DIM_W'(width_r);
    end
    if (height_r == '0) begin
      h_c = HGT_W'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      h_c = HGT_W'(MAX_HEIGHT);
    end else begin
      h_c = HGT_W'(height_r);
    end
  end

  assign total      = POS_W'(w_c) * POS_W'(h_c);
  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid && cfg_ready &&
                      (cfg_reg_t'(cfg_index) == REG_WIDTH ||
                       cfg_reg_t'(cfg_index) == REG_HEIGHT);
  assign in_stall   = !q_ready || rd_busy;
  assign accept     = in_valid && !in_stall;
  assign is_pix     = accept && !in_item.kind && (in_pos_r < total);
  assign in_pos_inc = in_pos_r + POS_W'(1);
  assign pos_gap    = in_pos_inc - out_pos_r;
  assign last       = (out_pos_r == total - POS_W'(1));

  always_comb begin
    if (is_pix) begin
      emit = (pos_gap >= POS_W'(w_c) + POS_W'(2));
    end else begin
      emit = accept && (in_pos_r >= total) && (out_pos_r < total);
    end
  end

  assign in_idx_nxt  = (in_idx_r == IDX_W'(HIST_DEPTH - 1)) ? '0 : in_idx_r + IDX_W'(1);
  assign out_idx_nxt = (out_idx_r == IDX_W'(HIST_DEPTH - 1)) ? '0 : out_idx_r + IDX_W'(1);

  assign q_push       = emit;
  assign q_job.col    = out_col_r;
  assign q_job.row    = out_row_r;
  assign q_job.idx    = out_idx_r;
  assign q_job.last   = last;
  assign hist_wr.en   = is_pix;
  assign hist_wr.idx  = in_idx_r;
  assign hist_wr.data = {in_item.red_in, in_item.green_in, in_item.blue_in};
  assign dims.w       = w_c;
  assign dims.h       = h_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WREG_W'(1024);
      height_r  <= HREG_W'(1024);
      in_pos_r  <= '0;
      out_pos_r <= '0;
      in_idx_r  <= '0;
      out_idx_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_reg_t'(cfg_index) == REG_WIDTH) begin
        width_r <= cfg_data[WREG_W-1:0];
      end else begin
        height_r <= cfg_data[HREG_W-1:0];
      end
      in_pos_r  <= '0;
      out_pos_r <= '0;
      in_idx_r  <= '0;
      out_idx_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (accept) begin
      if (emit && last) begin
        in_pos_r  <= '0;
        out_pos_r <= '0;
        in_idx_r  <= '0;
        out_idx_r <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        if (is_pix) begin
          in_pos_r <= in_pos_inc;
          in_idx_r <= in_idx_nxt;
        end
        if (emit) begin
          out_pos_r <= out_pos_r + POS_W'(1);
          out_idx_r <= out_idx_nxt;
          if (DIM_W'(out_col_r) + DIM_W'(1) >= w_c) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + ROW_W'(1);
          end else begin
            out_col_r <= out_col_r + COL_W'(1);
          end
        end
      end
    end
  end

endmodule

// ----- src/sem_jobq.sv -----
`timescale 1ns / 1ps
module sem_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sem_pkg::job_t push_job,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output sem_pkg::job_t pop_job
);
  import sem_pkg::*;

  logic valid_r;
  job_t job_r;

  assign push_ready = !valid_r;
  assign pop_valid  = valid_r;
  assign pop_job    = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push && !valid_r) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !valid_r) begin
      job_r <= push_job;
    end
  end

endmodule

// ----- src/sem_back.sv -----
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_assert.svh"
module sem_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  sem_pkg::job_t     job_in,
  output logic              job_pop,
  output logic              rd_busy,
  input  sem_pkg::hist_wr_t hist_wr,
  input  sem_pkg::dims_t    dims,
  output logic              out_valid,
  input  logic              out_stall,
  output sem_pkg::out_item_t out_item
);
  import sem_pkg::*;

  logic [23:0]            hist_mem [HIST_DEPTH];
  logic [23:0]            rd_data_r;
  back_state_t            state_r, state_nxt;
  logic [KS_W-1:0]        k_r, rd_k_r;
  logic                   rd_v_r, rd_ok_r;
  job_t                   job_r;
  logic signed [G_W-1:0]  gx_r [3];
  logic signed [G_W-1:0]  gy_r [3];
  logic [SQ_W-1:0]        sqx_r [3];
  logic [SQ_W-1:0]        sqy_r [3];
  logic [N_W:0]           rem_r [3];
  logic [N_W:0]           root_r [3];
  logic [N_W:0]           bit_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic [1:0]             dr, dc;
  logic                   ok_row, ok_col;
  logic [IDX_W:0]         t0, t1, u0, u1;
  logic [IDX_W-1:0]       rd_addr;
  logic                   out_free, load_out;
  logic [7:0]             edge_c [3];

  // window address: centre index stepped by one row and one column, modulo depth
  always_comb begin
    dr = win_row(k_r);
    dc = win_col(k_r);
    unique case (dr)
      2'd0:    t0 = (IDX_W+1)'(job_r.idx) + (IDX_W+1)'(HIST_DEPTH) - (IDX_W+1)'(dims.w);
      2'd2:    t0 = (IDX_W+1)'(job_r.idx) + (IDX_W+1)'(dims.w);
      default: t0 = (IDX_W+1)'(job_r.idx);
    endcase
    t1 = (t0 >= (IDX_W+1)'(HIST_DEPTH)) ? t0 - (IDX_W+1)'(HIST_DEPTH) : t0;
    unique case (dc)
      2'd0:    u0 = t1 + (IDX_W+1)'(HIST_DEPTH - 1);
      2'd2:    u0 = t1 + (IDX_W+1)'(1);
      default: u0 = t1;
    endcase
    u1      = (u0 >= (IDX_W+1)'(HIST_DEPTH)) ? u0 - (IDX_W+1)'(HIST_DEPTH) : u0;
    rd_addr = u1[IDX_W-1:0];
    unique case (dr)
      2'd0:    ok_row = (job_r.row != '0);
      2'd2:    ok_row = (HGT_W'(job_r.row) + HGT_W'(1) < dims.h);
      default: ok_row = 1'b1;
    endcase
    unique case (dc)
      2'd0:    ok_col = (job_r.col != '0);
      2'd2:    ok_col = (DIM_W'(job_r.col) + DIM_W'(1) < dims.w);
      default: ok_col = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hist_wr.en) begin
      hist_mem[hist_wr.idx] <= hist_wr.data;
    end
    rd_data_r <= hist_mem[rd_addr];
  end

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (job_valid) state_nxt = B_READ;
      B_READ:  if (k_r == KS_W'(LAST_K)) state_nxt = B_DRAIN;
      B_DRAIN: state_nxt = B_SQ;
      B_SQ:    state_nxt = B_SUM;
      B_SUM:   state_nxt = B_ROOT;
      B_ROOT:  if (cnt_r == '0) state_nxt = B_FIN;
      B_FIN:   if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    job_pop  = (state_r == B_IDLE) && job_valid;
    rd_busy  = (state_r == B_READ);
    load_out = (state_r == B_FIN) && out_free;
  end

  // rounding and saturation of the finished roots
  always_comb begin
    logic [N_W:0] rr;
    for (int ch = 0; ch < 3; ch++) begin
      rr = root_r[ch] + ((rem_r[ch] > root_r[ch]) ? (N_W+1)'(1) : '0);
      edge_c[ch] = (rr > (N_W+1)'(255)) ? 8'hFF : rr[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == B_READ);
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [N_W:0] t;
    logic signed [2*G_W-1:0] px, py;
    if (job_pop) begin
      job_r <= job_in;
      k_r   <= '0;
      for (int ch = 0; ch < 3; ch++) begin
        gx_r[ch] <= '0;
        gy_r[ch] <= '0;
      end
    end
    if (state_r == B_READ) begin
      k_r     <= k_r + KS_W'(1);
      rd_k_r  <= k_r;
      rd_ok_r <= ok_row && ok_col;
    end
    if (rd_v_r && rd_ok_r) begin
      for (int ch = 0; ch < 3; ch++) begin
        gx_r[ch] <= gx_r[ch] + weigh(rd_data_r[8*(2-ch) +: 8], kern_x(rd_k_r));
        gy_r[ch] <= gy_r[ch] + weigh(rd_data_r[8*(2-ch) +: 8], kern_y(rd_k_r));
      end
    end
    if (state_r == B_SQ) begin
      for (int ch = 0; ch < 3; ch++) begin
        // full-width signed products, squares fit in SQ_W bits
        px = gx_r[ch] * gx_r[ch];
        py = gy_r[ch] * gy_r[ch];
        sqx_r[ch] <= px[SQ_W-1:0];
        sqy_r[ch] <= py[SQ_W-1:0];
      end
    end
    if (state_r == B_SUM) begin
      for (int ch = 0; ch < 3; ch++) begin
        rem_r[ch]  <= (N_W+1)'(sqx_r[ch]) + (N_W+1)'(sqy_r[ch]);
        root_r[ch] <= '0;
      end
      bit_r <= (N_W+1)'(1) << (2 * (ROOT_STEPS - 1));
      cnt_r <= CNT_W'(ROOT_STEPS - 1);
    end
    if (state_r == B_ROOT) begin
      for (int ch = 0; ch < 3; ch++) begin
        t = root_r[ch] + bit_r;
        if (rem_r[ch] >= t) begin
          rem_r[ch]  <= rem_r[ch] - t;
          root_r[ch] <= (root_r[ch] >> 1) + bit_r;
        end else begin
          root_r[ch] <= root_r[ch] >> 1;
        end
      end
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (load_out) begin
      out_r.red_edge   <= edge_c[0];
      out_r.green_edge <= edge_c[1];
      out_r.blue_edge  <= edge_c[2];
      out_r.frame_last <= job_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `SEM_ASSERT_IMP(a_no_wr_in_read, hist_wr.en, state_r != B_READ)
  `SEM_ASSERT_NXT(a_read_drains, state_r == B_READ && k_r == KS_W'(LAST_K), state_r == B_DRAIN)
  `SEM_ASSERT_IMP(a_pop_idle, job_pop, state_r == B_IDLE)
  `SEM_ASSERT_NXT(a_root_len, state_r == B_ROOT && cnt_r == '0, state_r == B_FIN)

endmodule

// ----- test/sobel_edge_magnitude_tb.sv -----
`timescale 1ns / 1ps
module sobel_edge_magnitude_tb;
  import sem_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_WAIT  = 60;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;

  sobel_edge_magnitude DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // predictor state: raster history, dimensions and positions
  logic [23:0] pix_hist [HIST_DEPTH];
  logic [WREG_W-1:0] width_reg;
  logic [HREG_W-1:0] height_reg;
  int unsigned in_col, in_row, out_col, out_row;

  in_item_t  pixel_queue [$];
  out_item_t edge_queue [$];
  int errors;
  int beats_in, beats_out, frames_seen;
  int idle_cycles;
  bit hold_long;

  function automatic logic [7:0] rounded_root(input int unsigned n);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    // round up where n lies past r*r + r
    if (n > r * r + r) r++;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  task automatic predict_edges(input in_item_t it);
    int unsigned w, h, total, ipos, opos, rr, cc;
    bit emit;
    int gx, gy, v, ch, k;
    logic [23:0] win [9];
    out_item_t res;
    int kx [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    int ky [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    total = w * h;
    ipos = in_row * w + in_col;
    opos = out_row * w + out_col;
    emit = 0;
    if (!it.kind && ipos < total) begin
      pix_hist[ipos % HIST_DEPTH] = {it.red_in, it.green_in, it.blue_in};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      ipos++;
      if (ipos - opos >= w + 2) emit = 1;
    end else if (ipos >= total && opos < total) begin
      emit = 1;
    end
    if (!emit) return;
    for (k = 0; k < 9; k++) begin
      rr = out_row + k / 3 - 1;
      cc = out_col + k % 3 - 1;
      // wrap of unsigned below zero lands far outside the frame
      if (out_row + k / 3 < 1 || out_col + k % 3 < 1 || rr >= h || cc >= w) win[k] = '0;
      else win[k] = pix_hist[(rr * w + cc) % HIST_DEPTH];
    end
    for (ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (k = 0; k < 9; k++) begin
        v = int'((win[k] >> (16 - 8 * ch)) & 24'hFF);
        gx += v * kx[k];
        gy += v * ky[k];
      end
      case (ch)
        0: res.red_edge = rounded_root(gx * gx + gy * gy);
        1: res.green_edge = rounded_root(gx * gx + gy * gy);
        default: res.blue_edge = rounded_root(gx * gx + gy * gy);
      endcase
    end
    res.frame_last = (opos == total - 1);
    edge_queue.push_back(res);
    if (res.frame_last) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at result %0d: got %0d, want %0d", what, beats_out, got, want);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: bursts with random gaps; valid never looks at stall
  int gap_left, burst_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (in_valid && !in_stall) begin
      predict_edges(in_item);
      beats_in <= beats_in + 1;
      void'(pixel_queue.pop_front());
      if (pixel_queue.size() != 0 && burst_left != 0) begin
        in_item <= pixel_queue[0];
        burst_left <= burst_left - 1;
      end else begin
        in_valid <= 1'b0;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else if (!in_valid) begin
      if (gap_left != 0) gap_left <= gap_left - 1;
      else if (pixel_queue.size() != 0) begin
        in_valid <= 1'b1;
        in_item <= pixel_queue[0];
        burst_left <= $urandom_range(0, 40);
      end
    end
  end

  // monitor and receiver stall pattern
  int stall_mode, hold_cnt;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out <= beats_out + 1;
        if (edge_queue.size() == 0) begin
          $display("result with no expectation waiting at result %0d", beats_out);
          errors++;
        end else begin
          if (out_item.red_edge !== edge_queue[0].red_edge)
            report_mismatch("red_edge", out_item.red_edge, edge_queue[0].red_edge);
          if (out_item.green_edge !== edge_queue[0].green_edge)
            report_mismatch("green_edge", out_item.green_edge, edge_queue[0].green_edge);
          if (out_item.blue_edge !== edge_queue[0].blue_edge)
            report_mismatch("blue_edge", out_item.blue_edge, edge_queue[0].blue_edge);
          if (out_item.frame_last !== edge_queue[0].frame_last)
            report_mismatch("frame_last", out_item.frame_last, edge_queue[0].frame_last);
          if (out_item.frame_last) frames_seen <= frames_seen + 1;
          void'(edge_queue.pop_front());
        end
      end
      // a long hold-off fills the pipeline and must back up the input
      if (hold_long && hold_cnt == 0) hold_cnt <= 600;
      if (hold_cnt > 1) begin
        out_stall <= 1'b1;
        hold_cnt <= hold_cnt - 1;
      end else begin
        if (hold_cnt == 1) hold_cnt <= 0;
        stall_mode = ($urandom_range(0, 99) < 30) ? 1 : 0;
        out_stall <= stall_mode[0] && ($urandom_range(0, 2) != 0);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) || pixel_queue.size() == 0 && edge_queue.size() == 0)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  function automatic in_item_t rand_pixel(input int flush_pct);
    in_item_t it;
    it.kind = ($urandom_range(0, 99) < flush_pct);
    it.red_in = 8'($urandom);
    it.green_in = 8'($urandom);
    it.blue_in = 8'($urandom);
    return it;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_WIDTH) width_reg = WREG_W'(val);
    else if (idx == REG_HEIGHT) height_reg = HREG_W'(val);
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endtask

  // wait until every queued beat went in and every result came out
  task automatic settle();
    while (pixel_queue.size() != 0 || in_valid || edge_queue.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  task automatic frame_set(input int w, input int h, input int frames, input int junk_pct);
    int n, f, pw, ph;
    // frame size as the block uses it
    pw = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    ph = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    for (f = 0; f < frames; f++) begin
      for (n = 0; n < pw * ph; n++) pixel_queue.push_back(rand_pixel(junk_pct));
      // trailing flush ticks drain the results, a few spare ones are ignored
      for (n = 0; n < pw + 2 + $urandom_range(0, 2); n++) pixel_queue.push_back(rand_pixel(100));
    end
  endtask

  in_item_t di;
  int cfg_w, cfg_h, phase;
  initial begin
    rst_n = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; in_item = '0; out_stall = 0;
    width_reg = WREG_W'(1024); height_reg = HREG_W'(1024);
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    errors = 0; beats_in = 0; beats_out = 0; frames_seen = 0;
    hold_long = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: 3x3 frame with extremes, early flush, spare flush
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    di = '0; di.kind = 1; pixel_queue.push_back(di);
    for (int n = 0; n < 9; n++) begin
      di = '0;
      if (n % 2 == 0) begin di.red_in = 8'hFF; di.green_in = 8'hFF; di.blue_in = 8'hFF; end
      pixel_queue.push_back(di);
    end
    di = '0; di.red_in = 8'hFF; di.green_in = 8'hFF; di.blue_in = 8'hFF;
    pixel_queue.push_back(di); // pixel acting as flush
    for (int n = 0; n < 4; n++) begin di = '0; di.kind = 1; pixel_queue.push_back(di); end
    settle();
    // width and height of zero act as one
    frame_set(0, 0, 2, 0);
    settle();
    // width above maximum acts as maximum: part of a frame, enough to emit
    write_reg(REG_WIDTH, 2047);
    write_reg(REG_HEIGHT, 2);
    for (int n = 0; n < MAX_WIDTH + 6; n++) pixel_queue.push_back(rand_pixel(0));
    settle();
    // abandon a frame part way: the register write restarts it
    write_reg(REG_WIDTH, 4);
    write_reg(REG_HEIGHT, 4);
    for (int n = 0; n < 3; n++) pixel_queue.push_back(rand_pixel(0));
    settle();

    // random small frames, one long output hold-off along the way
    phase = 0;
    while (beats_in < 1800) begin
      cfg_w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) % 32 : $urandom_range(1, 12);
      cfg_h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) % 16 : $urandom_range(1, 8);
      frame_set(cfg_w, cfg_h, $urandom_range(1, 3), 5);
      if (phase == 3) begin
        hold_long = 1;
        repeat (2) @(posedge clk);
        hold_long = 0;
      end
      settle();
      phase++;
    end
    settle();

    $display("covered %0d input beats, %0d results, %0d frames over %0d settings",
             beats_in, beats_out, frames_seen, phase + 4);
    if (errors == 0 && edge_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, edge_queue.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/sem_pkg.sv
src/sem_front.sv
src/sem_jobq.sv
src/sem_back.sv
src/sobel_edge_magnitude.sv
test/sobel_edge_magnitude_tb.sv
